@@ src/stq_pkg.sv @@
package stq_pkg;

	// table size and per-advance expiry limit
	localparam int TimerSlots = 16;
	localparam int MaxResults = 16;

	// request codes
	localparam logic [1:0] ReqCreate  = 2'd0;
	localparam logic [1:0] ReqDestroy = 2'd1;
	localparam logic [1:0] ReqAdvance = 2'd2;

	// timer kinds
	localparam logic [1:0] KindOnce   = 2'd0;
	localparam logic [1:0] KindRepeat = 2'd1;

	// result codes
	localparam logic [1:0] ResCreated   = 2'd0;
	localparam logic [1:0] ResFull      = 2'd1;
	localparam logic [1:0] ResDestroyed = 2'd2;
	localparam logic [1:0] ResExpiry    = 2'd3;

	// one slot table entry
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] period;
		logic [15:0] tag;
		logic [63:0] deadline;
	} slot_ent_t;

endpackage

@@ src/stq_ram.sv @@
module stq_ram #(
	parameter int Depth = stq_pkg::TimerSlots,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata
);

	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/sorted_timer_queue.sv @@
// Channel   Handshake              Fields
// request   start / busy           req_type timer_kind period user_tag slot_id elapsed
// result    result_valid (strobe)  result_kind out_slot out_tag last
//
// Create and destroy answer in the cycle after acceptance; a create of a
// once or repeating timer then inserts into the ordered chain, walking back
// from the tail past each larger entry. Destroy walks the chain. Advance
// walks the head, compacts the tail and re-inserts each repeating timer.
// Chain order and slot entries sit in two single-port-read RAMs; busy stays
// high meanwhile. Reset clears time, slot use and chain length; the receiver
// cannot stall.
module sorted_timer_queue #(
	parameter int TimerSlots = stq_pkg::TimerSlots
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [1:0]  timer_kind,
	input  logic [31:0] period,
	input  logic [15:0] user_tag,
	input  logic [3:0]  slot_id,
	input  logic [31:0] elapsed,
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [3:0]  out_slot,
	output logic [15:0] out_tag,
	output logic        last
);

	localparam int SW = $clog2(TimerSlots);
	localparam int CW = $clog2(TimerSlots + 1);
	localparam int NW = $clog2(stq_pkg::MaxResults + 1);
	localparam int RW = $clog2(stq_pkg::MaxResults);
	localparam int EW = $bits(stq_pkg::slot_ent_t);

	typedef enum logic [3:0] {
		ST_IDLE, ST_INS_A, ST_INS_B, ST_INS_C, ST_RM_A, ST_RM_B,
		ST_WK_A, ST_WK_B, ST_WK_C, ST_WK_END, ST_SH_A, ST_SH_B,
		ST_RP_A, ST_RP_B
	} state_t;

	state_t                state_q;
	logic [63:0]           now_q;
	logic [TimerSlots-1:0] used_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ins_i_q;
	logic [SW-1:0]         ins_slot_q;
	logic [63:0]           ins_key_q;
	logic                  ins_before_q;
	logic                  rep_mode_q;
	logic [CW-1:0]         rm_i_q;
	logic [SW-1:0]         rm_slot_q;
	logic                  found_q;
	logic [CW-1:0]         wk_i_q;
	logic [NW-1:0]         wk_n_q;
	logic [NW-1:0]         rep_n_q;
	logic [NW-1:0]         rp_k_q;
	logic [CW-1:0]         sh_j_q;
	logic [SW-1:0]         rep_q [stq_pkg::MaxResults];
	logic                  pend_v_q;
	logic [SW-1:0]         pend_slot_q;
	logic [15:0]           pend_tag_q;
	logic                  res_v_q;
	logic [1:0]            res_kind_q;
	logic [3:0]            res_slot_q;
	logic [15:0]           res_tag_q;
	logic                  res_last_q;

	// RAM ports
	logic                  ord_re, ord_we, sl_re, sl_we;
	logic [SW-1:0]         ord_raddr, ord_waddr, ord_wdata, ord_rd;
	logic [SW-1:0]         sl_raddr, sl_waddr;
	logic [EW-1:0]         sl_wdata, sl_rd_raw;
	stq_pkg::slot_ent_t    sl_rd, sl_new, sl_rep;

	logic                  free_ok;
	logic [SW-1:0]         free_idx;
	logic                  sid_ok;
	logic [SW-1:0]         sid_idx;
	logic                  ins_shift;
	logic                  dl_lt;
	logic                  walk_stop;

	stq_ram #(.Depth(TimerSlots), .Width(SW)) u_ord (
		.clk(clk), .re(ord_re), .raddr(ord_raddr), .rdata(ord_rd),
		.we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata)
	);

	stq_ram #(.Depth(TimerSlots), .Width(EW)) u_slot (
		.clk(clk), .re(sl_re), .raddr(sl_raddr), .rdata(sl_rd_raw),
		.we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata)
	);

	assign sl_rd = stq_pkg::slot_ent_t'(sl_rd_raw);

	// find the lowest free slot
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int s = TimerSlots - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				free_ok  = 1'b1;
				free_idx = SW'(s);
			end
		end
	end

	assign sid_ok    = 32'(slot_id) < 32'(TimerSlots);
	assign sid_idx   = SW'(slot_id);
	assign ins_shift = ins_before_q ? (sl_rd.deadline >= ins_key_q)
	                                : (sl_rd.deadline > ins_key_q);
	assign dl_lt     = sl_rd.deadline < now_q;
	assign walk_stop = (wk_i_q == count_q) || (wk_n_q == NW'(stq_pkg::MaxResults));

	// new and restarted slot entries
	always_comb begin
		sl_new.kind     = timer_kind;
		sl_new.period   = period;
		sl_new.tag      = user_tag;
		sl_new.deadline = now_q + 64'(period);
		sl_rep          = sl_rd;
		sl_rep.deadline = now_q + 64'(sl_rd.period);
	end

	// drive RAM ports from the sequencer state
	always_comb begin
		ord_re    = 1'b0;
		ord_raddr = '0;
		ord_we    = 1'b0;
		ord_waddr = '0;
		ord_wdata = '0;
		sl_re     = 1'b0;
		sl_raddr  = '0;
		sl_we     = 1'b0;
		sl_waddr  = '0;
		sl_wdata  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && req_type == stq_pkg::ReqCreate && free_ok) begin
					sl_we    = 1'b1;
					sl_waddr = free_idx;
					sl_wdata = EW'(sl_new);
				end
			end
			ST_INS_A: begin
				if (ins_i_q == '0) begin
					ord_we    = 1'b1;
					ord_waddr = '0;
					ord_wdata = ins_slot_q;
				end else begin
					ord_re    = 1'b1;
					ord_raddr = SW'(ins_i_q - CW'(1));
				end
			end
			ST_INS_B: begin
				sl_re    = 1'b1;
				sl_raddr = ord_rd;
			end
			ST_INS_C: begin
				ord_we    = 1'b1;
				ord_waddr = SW'(ins_i_q);
				ord_wdata = ins_shift ? ord_rd : ins_slot_q;
			end
			ST_RM_A: begin
				ord_re    = rm_i_q != count_q;
				ord_raddr = SW'(rm_i_q);
			end
			ST_RM_B: begin
				ord_we    = found_q;
				ord_waddr = SW'(rm_i_q - CW'(1));
				ord_wdata = ord_rd;
			end
			ST_WK_A: begin
				ord_re    = !walk_stop;
				ord_raddr = SW'(wk_i_q);
			end
			ST_WK_B: begin
				sl_re    = 1'b1;
				sl_raddr = ord_rd;
			end
			ST_WK_C: begin
				sl_we    = dl_lt && sl_rd.kind == stq_pkg::KindRepeat;
				sl_waddr = ord_rd;
				sl_wdata = EW'(sl_rep);
			end
			ST_SH_A: begin
				ord_re    = sh_j_q != count_q;
				ord_raddr = SW'(sh_j_q);
			end
			ST_SH_B: begin
				ord_we    = 1'b1;
				ord_waddr = SW'(sh_j_q - wk_i_q);
				ord_wdata = ord_rd;
			end
			ST_RP_A: begin
				sl_re    = rp_k_q != '0;
				sl_raddr = rep_q[RW'(rp_k_q - NW'(1))];
			end
			default: begin
			end
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			used_q   <= '0;
			count_q  <= '0;
			res_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (req_type)
							stq_pkg::ReqCreate: begin
								res_v_q    <= 1'b1;
								res_last_q <= 1'b1;
								if (!free_ok) begin
									res_kind_q <= stq_pkg::ResFull;
									res_slot_q <= '0;
									res_tag_q  <= '0;
								end else begin
									res_kind_q       <= stq_pkg::ResCreated;
									res_slot_q       <= 4'(free_idx);
									res_tag_q        <= user_tag;
									used_q[free_idx] <= 1'b1;
									ins_key_q        <= sl_new.deadline;
									ins_slot_q       <= free_idx;
									ins_i_q          <= count_q;
									ins_before_q     <= 1'b0;
									rep_mode_q       <= 1'b0;
									if ((timer_kind == stq_pkg::KindOnce ||
									     timer_kind == stq_pkg::KindRepeat) &&
									    count_q < CW'(TimerSlots)) begin
										state_q <= ST_INS_A;
									end
								end
							end
							stq_pkg::ReqDestroy: begin
								res_v_q    <= 1'b1;
								res_last_q <= 1'b1;
								res_kind_q <= stq_pkg::ResDestroyed;
								res_slot_q <= slot_id;
								res_tag_q  <= '0;
								if (sid_ok && used_q[sid_idx]) begin
									used_q[sid_idx] <= 1'b0;
									rm_slot_q       <= sid_idx;
									rm_i_q          <= '0;
									found_q         <= 1'b0;
									state_q         <= ST_RM_A;
								end
							end
							stq_pkg::ReqAdvance: begin
								now_q    <= now_q + 64'(elapsed);
								wk_i_q   <= '0;
								wk_n_q   <= '0;
								rep_n_q  <= '0;
								pend_v_q <= 1'b0;
								state_q  <= ST_WK_A;
							end
							default: begin
							end
						endcase
					end
				end
				// insert: walk back from the tail, shifting larger keys up (equal keys too on a re-insert)
				ST_INS_A: begin
					if (ins_i_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= rep_mode_q ? ST_RP_A : ST_IDLE;
					end else begin
						state_q <= ST_INS_B;
					end
				end
				ST_INS_B: state_q <= ST_INS_C;
				ST_INS_C: begin
					if (ins_shift) begin
						ins_i_q <= ins_i_q - CW'(1);
						state_q <= ST_INS_A;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= rep_mode_q ? ST_RP_A : ST_IDLE;
					end
				end
				// remove: close the gap behind the matching entry
				ST_RM_A: begin
					if (rm_i_q == count_q) begin
						if (found_q) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RM_B;
					end
				end
				ST_RM_B: begin
					if (ord_rd == rm_slot_q) begin
						found_q <= 1'b1;
					end
					rm_i_q  <= rm_i_q + CW'(1);
					state_q <= ST_RM_A;
				end
				// walk the head and fire expired timers
				ST_WK_A: state_q <= walk_stop ? ST_WK_END : ST_WK_B;
				ST_WK_B: state_q <= ST_WK_C;
				ST_WK_C: begin
					if (dl_lt) begin
						if (pend_v_q) begin
							res_v_q    <= 1'b1;
							res_kind_q <= stq_pkg::ResExpiry;
							res_slot_q <= 4'(pend_slot_q);
							res_tag_q  <= pend_tag_q;
							res_last_q <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_slot_q <= ord_rd;
						pend_tag_q  <= sl_rd.tag;
						wk_n_q      <= wk_n_q + NW'(1);
						wk_i_q      <= wk_i_q + CW'(1);
						if (sl_rd.kind == stq_pkg::KindRepeat) begin
							rep_q[RW'(rep_n_q)] <= ord_rd;
							rep_n_q             <= rep_n_q + NW'(1);
						end
						state_q <= ST_WK_A;
					end else begin
						state_q <= ST_WK_END;
					end
				end
				ST_WK_END: begin
					if (pend_v_q) begin
						res_v_q    <= 1'b1;
						res_kind_q <= stq_pkg::ResExpiry;
						res_slot_q <= 4'(pend_slot_q);
						res_tag_q  <= pend_tag_q;
						res_last_q <= 1'b1;
					end
					pend_v_q <= 1'b0;
					sh_j_q   <= wk_i_q;
					state_q  <= ST_SH_A;
				end
				// move the unexpired tail to the chain head
				ST_SH_A: begin
					if (sh_j_q == count_q) begin
						count_q <= count_q - wk_i_q;
						rp_k_q  <= rep_n_q;
						state_q <= ST_RP_A;
					end else begin
						state_q <= ST_SH_B;
					end
				end
				ST_SH_B: begin
					sh_j_q  <= sh_j_q + CW'(1);
					state_q <= ST_SH_A;
				end
				// re-insert repeaters, last fired first, ahead of equal keys
				ST_RP_A: begin
					if (rp_k_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rp_k_q  <= rp_k_q - NW'(1);
						state_q <= ST_RP_B;
					end
				end
				ST_RP_B: begin
					ins_slot_q   <= rep_q[RW'(rp_k_q)];
					ins_key_q    <= sl_rd.deadline;
					ins_i_q      <= count_q;
					ins_before_q <= 1'b1;
					rep_mode_q   <= 1'b1;
					state_q      <= ST_INS_A;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = res_v_q;
	assign result_kind  = res_kind_q;
	assign out_slot     = res_slot_q;
	assign out_tag      = res_tag_q;
	assign last         = res_last_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TimerSlots))
		else $error("chain length beyond table size");

	a_adv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == stq_pkg::ReqAdvance) |=> busy)
		else $error("advance request did not start the walk");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind != stq_pkg::ResExpiry) |-> last)
		else $error("single-result request without last");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		($past(!busy) && !$past(start)) |-> !result_valid)
		else $error("result without a request");
`endif

endmodule

@@ bench/sorted_timer_queue_tb.sv @@
`timescale 1ns / 1ps

module sorted_timer_queue_tb;

	// three more codes the package leaves out
	localparam logic [1:0] KindNever  = 2'd2;
	localparam logic [1:0] KindOdd    = 2'd3;
	localparam logic [1:0] ReqUnused  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [15:0] tag;
		logic        last;
	} timer_res_t;

	// predicts the timer table and holds the expected results
	class timer_scoreboard;
		logic [63:0] now = '0;
		bit          used [stq_pkg::TimerSlots];
		logic [1:0]  kinds [stq_pkg::TimerSlots];
		logic [31:0] periods [stq_pkg::TimerSlots];
		logic [63:0] deadlines [stq_pkg::TimerSlots];
		logic [15:0] tags [stq_pkg::TimerSlots];
		int          order [$];
		timer_res_t  pending [$];
		int          error_count = 0;

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			error_count++;
		endtask

		function int free_slot();
			foreach (used[i]) if (!used[i]) return i;
			return -1;
		endfunction

		function int live_slot();
			int picks [$];
			foreach (used[i]) if (used[i]) picks.insert(picks.size(), i);
			if (picks.size() == 0) return -1;
			return picks[$urandom_range(picks.size() - 1)];
		endfunction

		function void push(logic [1:0] k, int s, logic [15:0] t, bit l);
			timer_res_t r;
			r.kind = k; r.slot = s[3:0]; r.tag = t; r.last = l;
			pending.insert(pending.size(), r);
		endfunction

		// insert after entries with an equal deadline
		function void insert_sorted(int s);
			int pos = 0;
			while (pos < order.size() && deadlines[order[pos]] <= deadlines[s]) pos++;
			if (order.size() < stq_pkg::TimerSlots) order.insert(pos, s);
		endfunction

		function void note_request(logic [1:0] rq, logic [1:0] k, logic [31:0] p,
				logic [15:0] t, logic [3:0] sid, logic [31:0] el);
			int s, n, fired;
			int merged [$];
			logic [63:0] d;
			case (rq)
				stq_pkg::ReqCreate: begin
					s = free_slot();
					if (s < 0) begin
						push(stq_pkg::ResFull, 0, '0, 1'b1);
					end else begin
						used[s] = 1; kinds[s] = k; periods[s] = p; tags[s] = t;
						deadlines[s] = now + {32'd0, p};
						if (k == stq_pkg::KindOnce || k == stq_pkg::KindRepeat)
							insert_sorted(s);
						push(stq_pkg::ResCreated, s, t, 1'b1);
					end
				end
				stq_pkg::ReqDestroy: begin
					if (used[sid]) begin
						foreach (order[i]) if (order[i] == sid) begin
							order.delete(i);
							break;
						end
						used[sid] = 0;
					end
					push(stq_pkg::ResDestroyed, int'(sid), '0, 1'b1);
				end
				stq_pkg::ReqAdvance: begin
					now = now + {32'd0, el};
					n = 0;
					fired = 0;
					while (fired < order.size() && n < stq_pkg::MaxResults &&
							deadlines[order[fired]] < now) begin
						s = order[fired];
						push(stq_pkg::ResExpiry, s, tags[s], 1'b0);
						n++;
						if (kinds[s] == stq_pkg::KindRepeat) begin
							deadlines[s] = now + {32'd0, periods[s]};
							merged.insert(merged.size(), s);
						end
						fired++;
					end
					// re-sorted repeaters go ahead of equal untouched entries
					for (int j = fired; j < order.size(); j++)
						merged.insert(merged.size(), order[j]);
					for (int j = 1; j < merged.size(); j++) begin
						s = merged[j];
						d = deadlines[s];
						n = j;
						while (n > 0 && deadlines[merged[n-1]] > d) begin
							merged[n] = merged[n-1];
							n--;
						end
						merged[n] = s;
					end
					order = merged;
					if (pending.size() > 0 && fired > 0) pending[$].last = 1;
				end
				default: ;
			endcase
		endfunction

		task check_result(input timer_res_t got);
			timer_res_t exp;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result kind %0d slot %0d", got.kind, got.slot));
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind)
				report($sformatf("result_kind %0d, want %0d", got.kind, exp.kind));
			if (got.slot !== exp.slot)
				report($sformatf("out_slot %0d, want %0d", got.slot, exp.slot));
			if (got.tag !== exp.tag)
				report($sformatf("out_tag %h, want %h", got.tag, exp.tag));
			if (got.last !== exp.last)
				report($sformatf("last %b, want %b", got.last, exp.last));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  req_type = 0;
	logic [1:0]  timer_kind = 0;
	logic [31:0] period = 0;
	logic [15:0] user_tag = 0;
	logic [3:0]  slot_id = 0;
	logic [31:0] elapsed = 0;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [3:0]  out_slot;
	logic [15:0] out_tag;
	logic        last;

	timer_scoreboard board = new();

	sorted_timer_queue u_top (.*);

	always #5 clk = ~clk;

	// collect every strobed result
	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_result('{result_kind, out_slot, out_tag, last});
	end

	// issue one request and hold it until accepted; start stays up for the next one
	task automatic send_request(input logic [1:0] rq, input logic [1:0] k,
			input logic [31:0] p, input logic [15:0] t, input logic [3:0] sid,
			input logic [31:0] el);
		start <= 1; req_type <= rq; timer_kind <= k; period <= p;
		user_tag <= t; slot_id <= sid; elapsed <= el;
		do @(posedge clk); while (busy);
		board.note_request(rq, k, p, t, sid, el);
		@(negedge clk);
	endtask

	// drop start and wait
	task automatic idle_cycles(input int n);
		start <= 0;
		repeat (n) @(negedge clk);
	endtask

	// wait for every expected result to drain
	task automatic drain();
		idle_cycles(1);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// mostly short intervals so timers fire often
	function automatic logic [31:0] pick_time();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom_range(40);
		endcase
	endfunction

	task automatic random_request();
		int s;
		logic [3:0] sid;
		case ($urandom_range(9))
			0, 1, 2, 3:
				send_request(stq_pkg::ReqCreate, $urandom_range(9) == 0 ? KindOdd :
					2'($urandom_range(2)), pick_time(), 16'($urandom), 4'($urandom),
					$urandom);
			4, 5: begin
				s = board.live_slot();
				sid = (s < 0 || $urandom_range(4) == 0) ? 4'($urandom) : 4'(s);
				send_request(stq_pkg::ReqDestroy, 2'($urandom), $urandom,
					16'($urandom), sid, $urandom);
			end
			6: send_request(ReqUnused, 2'($urandom), $urandom, 16'($urandom),
				4'($urandom), $urandom);
			default:
				send_request(stq_pkg::ReqAdvance, 2'($urandom), $urandom,
					16'($urandom), 4'($urandom), pick_time());
		endcase
	endtask

	initial begin
		int burst;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		idle_cycles(2);

		// fill the table, overflow, and fire a full burst of expiries
		for (int i = 0; i < stq_pkg::TimerSlots; i++)
			send_request(stq_pkg::ReqCreate,
				i % 2 ? stq_pkg::KindRepeat : stq_pkg::KindOnce,
				i < 2 ? 32'd0 : 32'd5, i == 0 ? 16'hFFFF : 16'(i), 4'd0, 32'd0);
		send_request(stq_pkg::ReqCreate, KindNever, 32'hFFFF_FFFF, 16'h1234, 4'd0, 32'd0);
		send_request(stq_pkg::ReqAdvance, 2'd0, 32'd0, 16'd0, 4'd0, 32'd0);
		send_request(stq_pkg::ReqAdvance, 2'd0, 32'd0, 16'd0, 4'd0, 32'd10);
		send_request(stq_pkg::ReqAdvance, 2'd0, 32'd0, 16'd0, 4'd0, 32'hFFFF_FFFF);
		send_request(stq_pkg::ReqDestroy, 2'd0, 32'd0, 16'd0, 4'd15, 32'd0);
		send_request(stq_pkg::ReqDestroy, 2'd0, 32'd0, 16'd0, 4'd15, 32'd0);
		send_request(stq_pkg::ReqCreate, KindOdd, 32'd0, 16'h0, 4'd0, 32'd0);
		send_request(ReqUnused, 2'd0, 32'd0, 16'd0, 4'd0, 32'd0);
		drain();

		// bursts of random requests with gaps
		for (int n = 0; n < 500; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++, n++) random_request();
			if ($urandom_range(1)) idle_cycles($urandom_range(1, 30));
			if (n > 250 && n < 265) drain();
		end

		drain();
		if (board.error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
